[rtl/core/sha256_stream_hasher_unit_macros.svh]
// assertion macros shared by the sha-256 stream hasher checkers
// no dependencies; callers provide clk_i and rst_ni in scope
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SHS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shs assertion failed");

// next-cycle implication, disabled during reset
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`endif

[rtl/core/shs_pkg.sv]
// package for the sha-256 stream hasher: types, round constants, sigma functions
// no dependencies
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef logic [0:7][31:0] hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       load;
    logic       step;
  } shs_ctl_t;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam hash_t IV_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] K_TAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[rtl/core/shs_sched.sv]
// block buffer and message schedule window of the sha-256 stream hasher
// depends on shs_pkg
module shs_sched (
  input  logic             clk_i,
  input  shs_pkg::shs_ctl_t ctl_i,
  output shs_pkg::word_t   w_o
);
  import shs_pkg::*;

  logic [511:0] win_q, win_d;
  word_t        w0, w1, w9, w14, w_new;

  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
  assign w_o = w0;

  always_comb begin
    win_d = win_q;
    if (ctl_i.byte_en) begin
      win_d = {win_q[503:0], ctl_i.byte_val};
    end else if (ctl_i.step) begin
      win_d = {win_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

[rtl/core/shs_round.sv]
// working variables and shared round unit of the sha-256 stream hasher
// depends on shs_pkg
module shs_round (
  input  logic              clk_i,
  input  shs_pkg::shs_ctl_t ctl_i,
  input  shs_pkg::hash_t    hash_i,
  input  shs_pkg::word_t    w_i,
  input  logic [5:0]        rnd_i,
  output shs_pkg::hash_t    v_o
);
  import shs_pkg::*;

  hash_t v_q, v_d;
  word_t t1, t2, ch, maj;

  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + bsig1(v_q[4]) + ch + K_TAB[rnd_i] + w_i;
    t2  = bsig0(v_q[0]) + maj;
    v_d = v_q;
    if (ctl_i.load) begin
      v_d = hash_i;
    end else if (ctl_i.step) begin
      v_d = {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

[rtl/core/sha256_stream_hasher_unit.sv]
// sha-256 stream hasher: one message byte per input beat, digest out as eight words
// slave side: tdata = data byte, tuser = action (0 absorb, 1 finish)
// master side: tdata = digest word, tuser = word index, tlast = final word
// a byte that does not complete a 64-byte block is taken and the input stays ready
// the 64th byte of a block starts the round steps and then the fold step,
// all run on a single shared round unit, and the input is not ready meanwhile
// a finish beat shifts in padding one byte a cycle up to the block end and
// compresses, and when more than 55 bytes were pending does one more block
// of padding and compression
// then the eight digest words are offered in order, one beat per cycle while taken
// while the receiver stalls the word and index hold and no input is taken
// after the last word is taken the hash, bit count and fill return to their
// initial values and the block is ready for the next message
// reset (rst_ni low, asynchronous) brings the same initial state
// depends on shs_pkg, shs_sched and shs_round
module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);
  import shs_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        fin_q, fin_d;
  logic        first_q, first_d;
  logic        lenok_q, lenok_d;
  hash_t       hash_q, hash_d;

  shs_ctl_t    ctl;
  word_t       w;
  hash_t       v;
  logic        s_acc;
  logic        m_acc;
  logic [63:0] len_sh;
  logic [7:0]  pad_byte;

  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign len_sh = bits_q >> {~fill_q[2:0], 3'b000};

  always_comb begin
    if (first_q) begin
      pad_byte = PAD_MARK;
    end else if (lenok_q && fill_q >= LEN_POS) begin
      pad_byte = len_sh[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i) begin
            state_d = ST_PAD;
          end else if (fill_q == LAST_POS) begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == LAST_POS) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (lenok_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i && idx_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    m_axis_tvalid_o = (state_q == ST_OUT);
    ctl.byte_en  = (state_q == ST_PAD) ||
                   ((state_q == ST_IDLE) && s_axis_tvalid_i && !s_axis_tuser_i);
    ctl.byte_val = (state_q == ST_PAD) ? pad_byte : s_axis_tdata_i;
    ctl.load     = ctl.byte_en && (fill_q == LAST_POS);
    ctl.step     = (state_q == ST_ROUND);
  end

  assign m_axis_tdata_o = hash_q[idx_q];
  assign m_axis_tuser_o = idx_q;
  assign m_axis_tlast_o = (idx_q == LAST_WORD);

  // datapath
  always_comb begin
    fill_d  = fill_q;
    bits_d  = bits_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    first_d = first_q;
    lenok_d = lenok_q;
    hash_d  = hash_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i) begin
            fin_d   = 1'b1;
            first_d = 1'b1;
          end else begin
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + BITS_PER_BYTE;
          end
        end
      end
      ST_PAD: begin
        fill_d  = fill_q + 6'd1;
        first_d = 1'b0;
        if (first_q) begin
          lenok_d = (fill_q < LEN_POS);
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v[i];
        end
        if (fin_q) begin
          lenok_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_WORD) begin
            hash_d  = IV_INIT;
            bits_d  = '0;
            fill_d  = '0;
            fin_d   = 1'b0;
            lenok_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      first_q <= 1'b0;
      lenok_q <= 1'b0;
      hash_q  <= IV_INIT;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
      first_q <= first_d;
      lenok_q <= lenok_d;
      hash_q  <= hash_d;
    end
  end

  shs_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w)
  );

  shs_round u_round (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .hash_i (hash_q),
    .w_i    (w),
    .rnd_i  (rnd_q),
    .v_o    (v)
  );

endmodule

[rtl/core/shs_checker.sv]
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends on sha256_stream_hasher_unit_macros.svh
`include "sha256_stream_hasher_unit_macros.svh"

module shs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  `SHS_ASSERT_IMPL(a_last_on_word7, m_axis_tvalid_o,
                   m_axis_tlast_o == (m_axis_tuser_o == 3'd7))

  `SHS_ASSERT_IMPL(a_no_input_while_out, m_axis_tvalid_o, !s_axis_tready_o)

  `SHS_ASSERT_NEXT(a_stall_holds, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  `SHS_ASSERT_NEXT(a_index_steps, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o,
                   m_axis_tvalid_o && (m_axis_tuser_o == 3'($past(m_axis_tuser_o) + 3'd1)))

  `SHS_ASSERT_NEXT(a_ready_after_digest, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o,
                   s_axis_tready_o && !m_axis_tvalid_o)

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (.*);

[bench/tb_top.sv]
// self-checking bench for sha256_stream_hasher_unit: bytes in, digest words out
// holds its own sha-256 model of the hash state and checks every digest beat
// depends on the rtl top level only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int CALM_TAIL    = 40;
  localparam int RANDOM_BEATS = 160;

  localparam logic [0:7][31:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser_i = 1'b0;    // [0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;           // [31:0] digest_word
  logic [2:0]  m_axis_tuser_o;           // [2:0] word_index
  logic        m_axis_tlast_o;

  msg_beat_t    msg_q[$];
  digest_beat_t digest_q[$];

  logic [31:0] hash_st [0:7];
  logic [7:0]  blk [0:63];
  int          fill;
  logic [63:0] msg_bits;

  int in_beats = 0;
  int out_beats = 0;
  int errors = 0;
  int send_gap = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cyc = 0;
  bit byte_taken = 1'b0;
  bit idle_on = 1'b1;
  bit tail_quiet = 1'b0;
  bit long_done = 1'b0;

  always #5 clk_i = ~clk_i;

  sha256_stream_hasher_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_clear();
    for (int i = 0; i < 8; i++) hash_st[i] = HASH_INIT[i];
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    fill = 0;
    msg_bits = 64'd0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endfunction

  function automatic void hash_take(input logic act, input logic [7:0] b);
    int pos;
    digest_beat_t d;
    if (act == ACT_ABSORB) begin
      blk[fill] = b;
      fill++;
      msg_bits = msg_bits + 64'd8;
      if (fill == 64) begin
        sha_compress();
        fill = 0;
      end
    end else begin
      pos = fill;
      blk[pos] = 8'h80;
      pos++;
      // length no longer fits behind the marker
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        sha_compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        d.value = hash_st[i];
        d.idx = i[2:0];
        d.last = (i == 7);
        digest_q.push_back(d);
      end
      hash_clear();
    end
  endfunction

  function automatic void push_beat(input logic act, input logic [7:0] b);
    msg_beat_t m;
    m.action = act;
    m.data = b;
    msg_q.push_back(m);
  endfunction

  function automatic void push_message(input int len);
    for (int i = 0; i < len; i++) push_beat(ACT_ABSORB, 8'($urandom_range(0, 255)));
    push_beat(ACT_FINISH, 8'($urandom_range(0, 255)));
  endfunction

  // input side: acceptance and prediction
  always @(posedge clk_i) begin
    cyc++;
    if (cyc % 128 == 0) idle_on = ($urandom_range(0, 2) != 0);
    tail_quiet = (msg_q.size() < CALM_TAIL);
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      byte_taken = 1'b1;
      in_beats++;
      hash_take(s_axis_tuser_i, s_axis_tdata_i);
      if (idle_on && !tail_quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 8);
    end
  end

  always @(negedge clk_i) begin
    msg_beat_t nxt;
    if (rst_ni && (!s_axis_tvalid_i || byte_taken)) begin
      byte_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (msg_q.size() > 0) begin
        nxt = msg_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= nxt.data;
        s_axis_tuser_i <= nxt.action;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // output side: digest checking
  always @(posedge clk_i) begin
    digest_beat_t exp_d;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      out_beats++;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest beat %h idx %0d last %b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        exp_d = digest_q.pop_front();
        if (m_axis_tdata_o !== exp_d.value) begin
          errors++;
          $display("%0t: digest word expected %h actual %h", $time, exp_d.value,
                   m_axis_tdata_o);
        end
        if (m_axis_tuser_o !== exp_d.idx) begin
          errors++;
          $display("%0t: word index expected %0d actual %0d", $time, exp_d.idx,
                   m_axis_tuser_o);
        end
        if (m_axis_tlast_o !== exp_d.last) begin
          errors++;
          $display("%0t: last flag expected %b actual %b", $time, exp_d.last,
                   m_axis_tlast_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // long hold so the digest backs up and the input stalls
      if (!long_done && out_beats >= 24) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && !tail_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int boundary_len [5];
    int bsel;
    int rand_beats;
    int len;
    int stall_cnt;
    int seen;
    bit timed_out;

    boundary_len = '{56, 55, 64, 63, 57};
    hash_clear();

    // empty messages, byte ignored on finish
    push_beat(ACT_FINISH, 8'hff);
    push_beat(ACT_FINISH, 8'h00);
    // "abc"
    push_beat(ACT_ABSORB, 8'h61);
    push_beat(ACT_ABSORB, 8'h62);
    push_beat(ACT_ABSORB, 8'h63);
    push_beat(ACT_FINISH, 8'h5a);
    push_beat(ACT_ABSORB, 8'h00);
    push_beat(ACT_FINISH, 8'h00);
    push_beat(ACT_ABSORB, 8'hff);
    push_beat(ACT_FINISH, 8'hff);
    push_beat(ACT_ABSORB, 8'h80);
    push_beat(ACT_ABSORB, 8'h7f);
    push_beat(ACT_ABSORB, 8'h01);
    push_beat(ACT_FINISH, 8'ha5);

    bsel = 0;
    rand_beats = 0;
    while (rand_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 3) == 0) begin
        len = boundary_len[bsel % 5];
        bsel++;
      end else if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(0, 70);
      end else begin
        len = $urandom_range(0, 12);
      end
      push_message(len);
      rand_beats += len + 1;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    stall_cnt = 0;
    seen = 0;
    timed_out = 1'b0;
    while (!timed_out && (msg_q.size() > 0 || s_axis_tvalid_i || digest_q.size() > 0)) begin
      @(negedge clk_i);
      #1;
      if (in_beats + out_beats != seen) begin
        seen = in_beats + out_beats;
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
      if (stall_cnt >= STALL_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!timed_out && errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
